>>> hdl/ebc_pkg.sv
// Shared types, constants and helper functions for the Erlang-B/C probability core.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package ebc_pkg;

    localparam int MAX_SERVERS_DEF = 255;
    localparam int PROB_FRAC_BITS  = 16;
    localparam int FRAC_BITS       = 30;               // internal Q1.30
    localparam int DW              = 48;               // divider width
    localparam int PW              = PROB_FRAC_BITS + 1;
    localparam int RND_SH          = FRAC_BITS - PROB_FRAC_BITS;
    localparam logic [5:0] STEPS_INT  = 6'd48;
    localparam logic [5:0] STEPS_FRAC = 6'd30;
    localparam logic [30:0] ONE_Q30   = 31'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        DS_LOAD,    // a   = (lambda << 16) / mu
        DS_BSTEP,   // B   = t * 2^30 / (k * 2^30 + t)
        DS_RHO,     // rho = (a << 14) / c
        DS_ERLC     // C   = B * 2^30 / d
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_a;
        logic     loop_init;
        logic     take_b;
        logic     take_rho;
        logic     take_qc;
        logic     mul_start;
        logic     mul_rho;
        logic     qc_one;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic mu_zero;
        logic div_done;
        logic loop_done;
        logic queue_ok;
        logic b_ge_d;
    } t_stat;

    // Q1.30 -> Q1.PROB_FRAC_BITS, round half up
    function automatic logic [PW-1:0] to_out(input logic [30:0] x);
        logic [31:0] v;
        v = {1'b0, x};
        if (RND_SH > 0) begin
            v = (v + (32'(1) << (RND_SH - 1))) >> RND_SH;
        end
        return v[PW-1:0];
    endfunction

endpackage

>>> hdl/ebc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ebc_pkg for widths.
`timescale 1ns / 1ps

module ebc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ebc_pkg::DW-1:0] i_rem,    // initial partial remainder
    input  logic [ebc_pkg::DW-1:0] i_num,    // bits shifted in, MSB first
    input  logic [ebc_pkg::DW-1:0] i_den,
    input  logic [5:0]             i_steps,
    output logic                   o_done,
    output logic [ebc_pkg::DW-1:0] o_quot
);

    logic [ebc_pkg::DW-1:0] r_rem, n_rem, r_num, r_den, r_q;
    logic [5:0]             r_cnt;
    logic                   r_busy, r_done;
    logic [ebc_pkg::DW:0]   sh;
    logic                   ge;

    always_comb begin
        sh    = {r_rem, r_num[ebc_pkg::DW-1]};
        ge    = sh >= {1'b0, r_den};
        n_rem = ge ? ebc_pkg::DW'(sh - {1'b0, r_den}) : sh[ebc_pkg::DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[ebc_pkg::DW-2:0], 1'b0};
            r_q   <= {r_q[ebc_pkg::DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> hdl/ebc_datapath.sv
// Datapath: operand registers, shared multiplier, serial divider and result register.
// Depends on ebc_pkg and ebc_div; driven by ebc_ctrl commands.
`timescale 1ns / 1ps

module ebc_datapath #(
    parameter int MAX_SERVERS = ebc_pkg::MAX_SERVERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ebc_pkg::t_cmd          i_cmd,
    output ebc_pkg::t_stat         o_stat,
    input  logic [31:0]            i_lambda,
    input  logic [31:0]            i_mu,
    input  logic [7:0]             i_c,
    output logic [ebc_pkg::PW-1:0] o_block_prob,
    output logic [ebc_pkg::PW-1:0] o_queue_prob,
    output logic                   o_overloaded,
    output logic                   o_rate_error
);

    localparam int KW = $clog2(MAX_SERVERS + 1);
    localparam int DW = ebc_pkg::DW;

    logic [31:0]  r_lambda, r_mu, r_a;
    logic [KW-1:0] r_c, c_eff;
    logic [KW:0]   r_k;
    logic [30:0]  r_b, r_qc, d;
    logic [29:0]  r_rho;
    logic [62:0]  r_prod;
    logic [31:0]  mul_op;
    logic [46:0]  t;
    logic         queue_ok, mu_zero;
    logic [DW-1:0] div_rem, div_num, div_den, quot;
    logic [5:0]   div_steps;
    logic         div_done;
    logic [ebc_pkg::PW-1:0] r_blk, r_qp;
    logic         r_ovl, r_err;

    assign c_eff = (32'(i_c) > 32'(MAX_SERVERS)) ? KW'(MAX_SERVERS) : KW'(i_c);
    assign mu_zero  = (r_mu == 32'd0);
    assign queue_ok = (r_c != '0) && (DW'(r_a) < (DW'(r_c) << 16));
    assign t        = r_prod[62:16];
    // d = 1 - rho + rho*B, never above 1.0
    assign d        = 31'(ebc_pkg::ONE_Q30 - 31'(r_rho) + 31'(r_prod[60:30]));
    assign mul_op   = i_cmd.mul_rho ? {2'b0, r_rho} : r_a;

    always_comb begin
        div_rem   = '0;
        div_num   = '0;
        div_den   = '0;
        div_steps = ebc_pkg::STEPS_INT;
        unique case (i_cmd.div_sel)
            ebc_pkg::DS_LOAD: begin
                div_num = {r_lambda, 16'b0};
                div_den = DW'(r_mu);
            end
            ebc_pkg::DS_BSTEP: begin
                div_rem   = DW'(t);
                div_den   = (DW'(r_k) << ebc_pkg::FRAC_BITS) + DW'(t);
                div_steps = ebc_pkg::STEPS_FRAC;
            end
            ebc_pkg::DS_RHO: begin
                div_num = {2'b0, r_a, 14'b0};
                div_den = DW'(r_c);
            end
            ebc_pkg::DS_ERLC: begin
                div_rem   = DW'(r_b);
                div_den   = DW'(d);
                div_steps = ebc_pkg::STEPS_FRAC;
            end
            default: ;
        endcase
    end

    ebc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_rem   (div_rem),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lambda <= i_lambda;
            r_mu     <= i_mu;
            r_c      <= c_eff;
        end
        if (i_cmd.take_a) begin
            r_a <= (quot[DW-1:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
        end
        if (i_cmd.loop_init) begin
            r_b <= ebc_pkg::ONE_Q30;
            r_k <= (KW+1)'(1);
        end else if (i_cmd.take_b) begin
            r_b <= quot[30:0];
            r_k <= r_k + (KW+1)'(1);
        end
        if (i_cmd.take_rho) r_rho <= quot[29:0];
        if (i_cmd.qc_one) begin
            r_qc <= ebc_pkg::ONE_Q30;
        end else if (i_cmd.take_qc) begin
            r_qc <= quot[30:0];
        end
        if (i_cmd.mul_start) r_prod <= mul_op * r_b;
        if (i_cmd.fin) begin
            r_err <= mu_zero;
            r_ovl <= !mu_zero && !queue_ok;
            r_blk <= ebc_pkg::to_out(mu_zero ? ebc_pkg::ONE_Q30 : r_b);
            r_qp  <= ebc_pkg::to_out((mu_zero || !queue_ok) ? ebc_pkg::ONE_Q30 : r_qc);
        end
    end

    assign o_stat.mu_zero   = mu_zero;
    assign o_stat.div_done  = div_done;
    assign o_stat.loop_done = r_k > {1'b0, r_c};
    assign o_stat.queue_ok  = queue_ok;
    assign o_stat.b_ge_d    = r_b >= d;

    assign o_block_prob = r_blk;
    assign o_queue_prob = r_qp;
    assign o_overloaded = r_ovl;
    assign o_rate_error = r_err;

endmodule

>>> hdl/ebc_ctrl.sv
// Sequencer for the Erlang-B/C core: load, recursion loop, Erlang-C, output handshake.
// Depends on ebc_pkg; commands ebc_datapath.
`timescale 1ns / 1ps

module ebc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  ebc_pkg::t_stat i_stat,
    output ebc_pkg::t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DIVA_S = 14'b00000000000010,
        S_DIVA_W = 14'b00000000000100,
        S_CHECK  = 14'b00000000001000,
        S_MUL    = 14'b00000000010000,
        S_FD_S   = 14'b00000000100000,
        S_FD_W   = 14'b00000001000000,
        S_POST   = 14'b00000010000000,
        S_RHO_S  = 14'b00000100000000,
        S_RHO_W  = 14'b00001000000000,
        S_CMUL   = 14'b00010000000000,
        S_CD_S   = 14'b00100000000000,
        S_CD_W   = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_tready;
        o_cmd     = '0;
        o_cmd.div_sel = ebc_pkg::DS_LOAD;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVA_S;
                end
            end
            S_DIVA_S: begin
                if (i_stat.mu_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVA_W;
                end
            end
            S_DIVA_W: begin
                if (i_stat.div_done) begin
                    o_cmd.take_a    = 1'b1;
                    o_cmd.loop_init = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.loop_done ? S_POST : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_FD_S;
            end
            S_FD_S: begin
                o_cmd.div_sel   = ebc_pkg::DS_BSTEP;
                o_cmd.div_start = 1'b1;
                n_state         = S_FD_W;
            end
            S_FD_W: begin
                if (i_stat.div_done) begin
                    o_cmd.take_b = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_POST: begin
                n_state = i_stat.queue_ok ? S_RHO_S : S_DONE;
            end
            S_RHO_S: begin
                o_cmd.div_sel   = ebc_pkg::DS_RHO;
                o_cmd.div_start = 1'b1;
                n_state         = S_RHO_W;
            end
            S_RHO_W: begin
                if (i_stat.div_done) begin
                    o_cmd.take_rho = 1'b1;
                    n_state        = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_rho   = 1'b1;
                n_state         = S_CD_S;
            end
            S_CD_S: begin
                if (i_stat.b_ge_d) begin
                    o_cmd.qc_one = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div_sel   = ebc_pkg::DS_ERLC;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_CD_W;
                end
            end
            S_CD_W: begin
                if (i_stat.div_done) begin
                    o_cmd.take_qc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                // result register free or being emptied this cycle
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.fin = 1'b1;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

>>> hdl/erlang_b_c_probability_core.sv
// Top level of the Erlang-B/C probability core.
// Depends on ebc_pkg, ebc_ctrl and ebc_datapath.
`timescale 1ns / 1ps

// Takes lambda and mu (unsigned Q16.16) and a server count c per item and
// returns one result: Erlang-B blocking probability and Erlang-C queueing
// probability in Q1.16 (65536 = 1.0), plus overloaded (a >= c) and
// rate_error (mu == 0, both probabilities forced to 1.0). Server counts above
// MAX_SERVERS are clamped. One item is worked at a time: the load division
// a = lambda/mu, then c recursion steps (each a multiply plus a serial divide),
// then rho and Erlang-C when a < c, all on the single shared serial divider.
// A new item is taken as soon as the previous one has moved to the output
// register, even while that result still waits for i_m_axis_tready.

module erlang_b_c_probability_core #(
    parameter int MAX_SERVERS = ebc_pkg::MAX_SERVERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] arrival_rate, [63:32] service_rate, [71:64] server_count
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [16:0] block_prob, [33:17] queue_prob, [34] overloaded, [35] rate_error,
    // [39:36] zero
    output logic [39:0] o_m_axis_tdata
);

    ebc_pkg::t_cmd  cmd;
    ebc_pkg::t_stat stat;
    logic [ebc_pkg::PW-1:0] block_prob, queue_prob;
    logic overloaded, rate_error;

    ebc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ebc_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_lambda     (i_s_axis_tdata[31:0]),
        .i_mu         (i_s_axis_tdata[63:32]),
        .i_c          (i_s_axis_tdata[71:64]),
        .o_block_prob (block_prob),
        .o_queue_prob (queue_prob),
        .o_overloaded (overloaded),
        .o_rate_error (rate_error)
    );

    assign o_m_axis_tdata = {4'b0, rate_error, overloaded, queue_prob, block_prob};

endmodule
